FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define TLI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, clocked on clk, disabled in reset.
`define TLI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

FILE: hdl/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
`default_nettype none
package tli_pkg;
	localparam int DATA_W         = 32;
	localparam int IDX_W          = 6;
	localparam int SEG_W          = 6;
	localparam int PC_W           = 7;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 7;
	localparam int MAG_W          = 32;
	localparam int PROD_W         = 64;
	localparam int HINT_LIMIT     = 64;
	localparam int DEF_MAX_POINTS = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP      = 1'd1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

	typedef logic [2*DATA_W-1:0] entry_t;
endpackage
`default_nettype wire

FILE: hdl/tli_if.sv
// Item and result channel interfaces.
`default_nettype none
interface tli_item_if;
	import tli_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [IDX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0] entry_x;
	logic signed [DATA_W-1:0] entry_y;
	logic signed [DATA_W-1:0] query_x;
	modport source (output valid, kind, entry_index, entry_x, entry_y, query_x, input ready);
	modport sink (input valid, kind, entry_index, entry_x, entry_y, query_x, output ready);
endinterface

interface tli_result_if;
	import tli_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic [SEG_W-1:0]         segment;
	logic                     saturated;
	logic                     zero_width;
	modport source (output valid, value, segment, saturated, zero_width, input ready);
	modport sink (input valid, value, segment, saturated, zero_width, output ready);
endinterface
`default_nettype wire

FILE: hdl/table_linear_interpolator.sv
// Piecewise linear interpolator over a breakpoint table in RAM, with a segment hint.
// A load beat writes one (x, y) entry. A query reads the first and last entries (one RAM
// read each), then either finishes (one point or clamped end), reads the neighbouring entry
// (end with extrapolation on), or walks from the remembered segment one entry read per cycle,
// and interpolates: it forms the differences, does one 32x32 multiply, runs the serial
// 64-by-32-bit divider stage (load, one quotient bit per cycle, done) and rounds. A
// zero-width segment skips the multiply and divide and returns its left y. Only an idle block
// takes items; the divider and the single RAM read port set a query's duration. The result
// register frees the input side once a result moves into it, after any previous result is
// taken. Table entries read before being written return unspecified data.
`default_nettype none
module table_linear_interpolator #(
	parameter int MAX_POINTS = tli_pkg::DEF_MAX_POINTS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tli_pkg::CFG_DATA_W-1:0] cfg_data,
	tli_item_if.sink                            item,
	tli_result_if.source                        result
);
	import tli_pkg::*;

	localparam int MAXP_EFF = (MAX_POINTS < HINT_LIMIT) ? MAX_POINTS : HINT_LIMIT;
	localparam int AW       = $clog2(MAX_POINTS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ONE  = 4'd1;
	localparam logic [3:0] S_LO   = 4'd2;
	localparam logic [3:0] S_HI   = 4'd3;
	localparam logic [3:0] S_WLO  = 4'd4;
	localparam logic [3:0] S_WHI  = 4'd5;
	localparam logic [3:0] S_FLO  = 4'd6;
	localparam logic [3:0] S_FHI  = 4'd7;
	localparam logic [3:0] S_PREP = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;
	localparam logic [3:0] S_RND  = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]               state_q;
	logic [PC_W-1:0]          pc_q;
	logic                     ext_q;
	logic [SEG_W-1:0]         hint_q;
	logic [SEG_W-1:0]         k_q;
	logic [SEG_W-1:0]         last_q;
	logic signed [DATA_W-1:0] xq_q;
	logic signed [DATA_W-1:0] lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic [MAG_W-1:0]         ad_q, ady_q, adq_q;
	logic                     neg_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     div_start_q;
	logic signed [DATA_W-1:0] rv_q;
	logic                     rsat_q, rzw_q;

	logic                     ovalid_q;
	logic signed [DATA_W-1:0] oval_q;
	logic [SEG_W-1:0]         oseg_q;
	logic                     osat_q, ozw_q;

	logic                     accept, accept_q, accept_l;
	logic                     ram_we;
	entry_t                   rd_data;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] x_rd, y_rd;
	logic [PC_W-1:0]          n_c;
	logic [SEG_W-1:0]         kc;
	logic                     low_hit, high_hit, go_down, go_up;
	logic signed [DATA_W:0]   dx_c, dy_c, dq_c;
	logic                     div_done;
	logic [PROD_W-1:0]        quo;
	logic [MAG_W-1:0]         rem;
	logic                     rnd;
	logic [PROD_W:0]          quo1;
	logic                     big;
	logic signed [DATA_W+3:0] sum_c;
	logic                     out_free;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign accept_q   = accept && (item.kind == KIND_QUERY);
	assign accept_l   = accept && (item.kind == KIND_LOAD);
	assign ram_we     = accept_l && (32'(item.entry_index) < MAX_POINTS);
	assign out_free   = !ovalid_q || result.ready;

	assign x_rd = rd_data[2*DATA_W-1:DATA_W];
	assign y_rd = rd_data[DATA_W-1:0];

	always_comb begin
		if (pc_q == '0) begin
			n_c = PC_W'(1);
		end else if (pc_q > PC_W'(MAXP_EFF)) begin
			n_c = PC_W'(MAXP_EFF);
		end else begin
			n_c = pc_q;
		end
	end

	always_comb begin
		if (hint_q == '0) begin
			kc = SEG_W'(1);
		end else if (hint_q > last_q) begin
			kc = last_q;
		end else begin
			kc = hint_q;
		end
	end

	assign low_hit  = xq_q <= x_rd;
	assign high_hit = xq_q >= x_rd;
	assign go_down  = (xq_q < x_rd) && (k_q > SEG_W'(1));
	assign go_up    = (xq_q >= x_rd) && (k_q < last_q);

	always_comb begin
		rd_addr = '0;
		case (state_q)
			S_LO: begin
				if (low_hit) begin
					rd_addr = AW'(1);
				end else begin
					rd_addr = AW'(last_q);
				end
			end
			S_HI: begin
				if (high_hit) begin
					rd_addr = AW'(last_q - 1'b1);
				end else begin
					rd_addr = AW'(kc - 1'b1);
				end
			end
			S_WLO: begin
				if (go_down) begin
					rd_addr = AW'(k_q - SEG_W'(2));
				end else begin
					rd_addr = AW'(k_q);
				end
			end
			S_WHI: begin
				rd_addr = AW'(k_q + 1'b1);
			end
			default: rd_addr = '0;
		endcase
	end

	tli_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(item.entry_index)),
		.wdata({item.entry_x, item.entry_y}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	tli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (ad_q),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	assign dx_c = {hi_x_q[DATA_W-1], hi_x_q} - {lo_x_q[DATA_W-1], lo_x_q};
	assign dy_c = {hi_y_q[DATA_W-1], hi_y_q} - {lo_y_q[DATA_W-1], lo_y_q};
	assign dq_c = {xq_q[DATA_W-1], xq_q} - {lo_x_q[DATA_W-1], lo_x_q};

	assign rnd  = {1'b0, rem} >= ({1'b0, ad_q} - {1'b0, rem});
	assign quo1 = {1'b0, quo} + (PROD_W + 1)'(rnd);
	assign big  = quo1 > ((PROD_W + 1)'(1) << 34);
	assign sum_c = neg_q ? ((DATA_W + 4)'(lo_y_q) - $signed({1'b0, quo1[34:0]}))
	                     : ((DATA_W + 4)'(lo_y_q) + $signed({1'b0, quo1[34:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= PC_W'(2);
			ext_q       <= 1'b0;
			hint_q      <= SEG_W'(1);
			div_start_q <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POINT_COUNT: pc_q <= cfg_data;
					CFG_EXTRAP:      ext_q <= cfg_data[0];
					default: ;
				endcase
			end
			div_start_q <= (state_q == S_MUL);
			ovalid_q    <= (state_q == S_DONE && out_free) || (ovalid_q && !result.ready);
			case (state_q)
				S_IDLE: begin
					if (accept_q) begin
						state_q <= (n_c < PC_W'(2)) ? S_ONE : S_LO;
					end
				end
				S_ONE: state_q <= S_DONE;
				S_LO: begin
					if (!low_hit) begin
						state_q <= S_HI;
					end else if (ext_q) begin
						state_q <= S_FHI;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_HI: begin
					if (!high_hit) begin
						state_q <= S_WLO;
					end else if (ext_q) begin
						state_q <= S_FLO;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WLO: begin
					if (!go_down) begin
						state_q <= S_WHI;
					end
				end
				S_WHI: begin
					if (!go_up) begin
						state_q <= S_PREP;
					end
				end
				S_FLO: state_q <= S_PREP;
				S_FHI: state_q <= S_PREP;
				S_PREP: begin
					state_q <= (dx_c == '0) ? S_DONE : S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_RND;
					end
				end
				S_RND: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						hint_q  <= k_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				xq_q   <= item.query_x;
				last_q <= SEG_W'(n_c - 1'b1);
				rsat_q <= 1'b0;
				rzw_q  <= 1'b0;
			end
			S_ONE: begin
				rv_q <= y_rd;
				k_q  <= SEG_W'(1);
			end
			S_LO: begin
				rv_q   <= y_rd;
				k_q    <= SEG_W'(1);
				lo_x_q <= x_rd;
				lo_y_q <= y_rd;
			end
			S_HI: begin
				rv_q   <= y_rd;
				hi_x_q <= x_rd;
				hi_y_q <= y_rd;
				k_q    <= high_hit ? last_q : kc;
			end
			S_WLO: begin
				if (go_down) begin
					k_q <= k_q - 1'b1;
				end else begin
					lo_x_q <= x_rd;
					lo_y_q <= y_rd;
				end
			end
			S_WHI: begin
				if (go_up) begin
					k_q    <= k_q + 1'b1;
					lo_x_q <= x_rd;
					lo_y_q <= y_rd;
				end else begin
					hi_x_q <= x_rd;
					hi_y_q <= y_rd;
				end
			end
			S_FLO: begin
				lo_x_q <= x_rd;
				lo_y_q <= y_rd;
			end
			S_FHI: begin
				hi_x_q <= x_rd;
				hi_y_q <= y_rd;
			end
			S_PREP: begin
				rv_q  <= lo_y_q;
				rzw_q <= (dx_c == '0);
				ad_q  <= dx_c[DATA_W] ? MAG_W'(-dx_c) : dx_c[MAG_W-1:0];
				ady_q <= dy_c[DATA_W] ? MAG_W'(-dy_c) : dy_c[MAG_W-1:0];
				adq_q <= dq_c[DATA_W] ? MAG_W'(-dq_c) : dq_c[MAG_W-1:0];
				neg_q <= dx_c[DATA_W] ^ dy_c[DATA_W] ^ dq_c[DATA_W];
			end
			S_MUL: begin
				prod_q <= PROD_W'(ady_q) * PROD_W'(adq_q);
			end
			S_RND: begin
				if (big) begin
					rsat_q <= 1'b1;
					rv_q   <= neg_q ? VAL_MIN : VAL_MAX;
				end else if (sum_c[DATA_W+3:DATA_W-1] != {5{sum_c[DATA_W+3]}}) begin
					rsat_q <= 1'b1;
					rv_q   <= sum_c[DATA_W+3] ? VAL_MIN : VAL_MAX;
				end else begin
					rv_q <= sum_c[DATA_W-1:0];
				end
			end
			default: ;
		endcase
		if (state_q == S_DONE && out_free) begin
			oval_q <= rv_q;
			oseg_q <= k_q;
			osat_q <= rsat_q;
			ozw_q  <= rzw_q;
		end
	end

	assign result.valid      = ovalid_q;
	assign result.value      = oval_q;
	assign result.segment    = oseg_q;
	assign result.saturated  = osat_q;
	assign result.zero_width = ozw_q;
endmodule
`default_nettype wire

FILE: hdl/tli_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module tli_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/tli_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tli_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tli_pkg::PROD_W-1:0] dividend,
	input  wire logic [tli_pkg::MAG_W-1:0]  divisor,
	output logic                            done,
	output logic      [tli_pkg::PROD_W-1:0] quotient,
	output logic      [tli_pkg::MAG_W-1:0]  remainder
);
	import tli_pkg::*;
	localparam int CNT_W = $clog2(PROD_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

	logic [PROD_W-1:0] num_q;
	logic [MAG_W-1:0]  rem_q;
	logic [MAG_W-1:0]  den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [MAG_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, num_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[PROD_W-2:0], ge};
			rem_q <= ge ? MAG_W'(trial - {1'b0, den_q}) : trial[MAG_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

FILE: hdl/tli_checker.sv
// Port-level checker for the table linear interpolator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module tli_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       item_valid,
	input wire logic                       item_ready,
	input wire logic                       item_kind,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic [tli_pkg::SEG_W-1:0]  res_segment,
	input wire logic                       res_saturated,
	input wire logic                       res_zero_width
);
	import tli_pkg::*;

	`TLI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
	`TLI_ASSERT_SAME(a_seg_nonzero, res_valid, res_segment != '0)
	`TLI_ASSERT_SAME(a_flags_excl, res_valid, !(res_saturated && res_zero_width))
	`TLI_ASSERT_NEXT(a_load_one_beat, item_valid && item_ready && item_kind == KIND_LOAD, item_ready)
	`TLI_ASSERT_NEXT(a_query_busy, item_valid && item_ready && item_kind == KIND_QUERY, !item_ready)
endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.item_kind     (item.kind),
	.res_valid     (result.valid),
	.res_ready     (result.ready),
	.res_segment   (result.segment),
	.res_saturated (result.saturated),
	.res_zero_width(result.zero_width)
);
`default_nettype wire

FILE: verif/table_linear_interpolator_test.sv
// Self-checking testbench for table_linear_interpolator: table loads, clamp, extrapolation, random queries.
`default_nettype none
module table_linear_interpolator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tli_pkg::*;

	typedef struct {
		logic                     kind;
		logic [IDX_W-1:0]         entry_index;
		logic signed [DATA_W-1:0] entry_x;
		logic signed [DATA_W-1:0] entry_y;
		logic signed [DATA_W-1:0] query_x;
	} beat_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [SEG_W-1:0]         segment;
		logic                     saturated;
		logic                     zero_width;
	} interp_t;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_POINT_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tli_item_if item ();
	tli_result_if result ();

	table_linear_interpolator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item.sink),
		.result(result.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic signed [DATA_W-1:0] curve_x [64];
	logic signed [DATA_W-1:0] curve_y [64];
	int unsigned bend_hint = 1;
	int unsigned points_reg = 2;
	bit extrap_reg = 1'b0;

	beat_t pending_beats[$];
	interp_t expected_interps[$];
	beat_t cur_beat;
	bit holding = 1'b0;
	bit steady = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int mismatches = 0;
	int queries_sent = 0;
	int loads_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint segment_line(int unsigned k, longint xq, ref bit sat, ref bit zw);
		longint x0, x1, y0, y1, dx, dy, dq, v;
		bit [63:0] ad, mdy, mdq, prod, quo, rem;
		bit neg;
		x0 = curve_x[k-1];
		x1 = curve_x[k];
		y0 = curve_y[k-1];
		y1 = curve_y[k];
		dx = x1 - x0;
		dy = y1 - y0;
		dq = xq - x0;
		if (dx == 0) begin
			zw = 1'b1;
			return y0;
		end
		ad = dx < 0 ? -dx : dx;
		mdy = dy < 0 ? -dy : dy;
		mdq = dq < 0 ? -dq : dq;
		prod = mdy * mdq;
		quo = prod / ad;
		rem = prod % ad;
		if (rem >= ad - rem)
			quo++;
		neg = (dx < 0) ^ (dy < 0) ^ (dq < 0);
		if (quo > 64'h4_0000_0000) begin
			sat = 1'b1;
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		end
		v = neg ? y0 - longint'(quo) : y0 + longint'(quo);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Applies one accepted beat to the predictor; queries queue an expected result.
	function automatic void interpolate_beat(beat_t b);
		int unsigned n, last, k;
		longint xq, v;
		bit sat, zw;
		interp_t r;
		sat = 0;
		zw = 0;
		if (b.kind == KIND_LOAD) begin
			curve_x[b.entry_index] = b.entry_x;
			curve_y[b.entry_index] = b.entry_y;
			return;
		end
		n = points_reg < 1 ? 1 : (points_reg > 64 ? 64 : points_reg);
		xq = b.query_x;
		if (n < 2) begin
			k = 1;
			v = curve_y[0];
		end else begin
			last = n - 1;
			if (xq <= longint'(curve_x[0])) begin
				k = 1;
				v = extrap_reg ? segment_line(k, xq, sat, zw) : longint'(curve_y[0]);
			end else if (xq >= longint'(curve_x[last])) begin
				k = last;
				v = extrap_reg ? segment_line(k, xq, sat, zw) : longint'(curve_y[last]);
			end else begin
				k = bend_hint;
				if (k < 1)
					k = 1;
				if (k > last)
					k = last;
				for (int s = 0; s < 64; s++) begin
					if (xq < longint'(curve_x[k-1]) && k > 1)
						k--;
					else if (xq >= longint'(curve_x[k]) && k < last)
						k++;
					else
						break;
				end
				v = segment_line(k, xq, sat, zw);
			end
		end
		bend_hint = k & 6'h3F;
		r.value = v[31:0];
		r.segment = k[5:0];
		r.saturated = sat;
		r.zero_width = zw;
		expected_interps.push_back(r);
	endfunction

	initial begin
		item.valid = 1'b0;
		item.kind = KIND_LOAD;
		item.entry_index = '0;
		item.entry_x = '0;
		item.entry_y = '0;
		item.query_x = '0;
		result.ready = 1'b0;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit next_valid;
		if (!arst_n) begin
			item.valid <= 1'b0;
			holding = 1'b0;
		end else begin
			next_valid = holding;
			if (holding && item.ready) begin
				interpolate_beat(cur_beat);
				if (cur_beat.kind == KIND_QUERY)
					queries_sent++;
				else
					loads_sent++;
				holding = 1'b0;
				next_valid = 1'b0;
				gap_left = pick_gap();
			end
			if (!holding) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_beats.size() != 0) begin
					cur_beat = pending_beats.pop_front();
					item.kind <= cur_beat.kind;
					item.entry_index <= cur_beat.entry_index;
					item.entry_x <= cur_beat.entry_x;
					item.entry_y <= cur_beat.entry_y;
					item.query_x <= cur_beat.query_x;
					holding = 1'b1;
					next_valid = 1'b1;
				end
			end
			item.valid <= next_valid;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		interp_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				results_seen++;
				if (expected_interps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: value %h segment %0d",
							result.value, result.segment);
				end else begin
					want = expected_interps.pop_front();
					if (result.value !== want.value || result.segment !== want.segment ||
						result.saturated !== want.saturated ||
						result.zero_width !== want.zero_width) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
								results_seen, want.value, want.segment, want.saturated,
								want.zero_width, result.value, result.segment,
								result.saturated, result.zero_width);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				result.ready <= (stall_left == 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_load(int idx, longint x, longint y);
		beat_t b;
		b.kind = KIND_LOAD;
		b.entry_index = idx[5:0];
		b.entry_x = x[31:0];
		b.entry_y = y[31:0];
		b.query_x = $urandom;
		pending_beats.push_back(b);
	endtask

	task automatic push_query(longint x);
		beat_t b;
		b.kind = KIND_QUERY;
		b.entry_index = $urandom;
		b.entry_x = $urandom;
		b.entry_y = $urandom;
		b.query_x = x[31:0];
		pending_beats.push_back(b);
	endtask

	task automatic drain();
		while (pending_beats.size() != 0 || holding || expected_interps.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d[CFG_DATA_W-1:0];
		if (idx == CFG_POINT_COUNT)
			points_reg = d & 7'h7F;
		else
			extrap_reg = d[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		longint gx [64];
		longint span, step, base;
		int n, nq, j, r, total;
		bit narrow;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// full-range two-point table, clamp mode after reset
		push_load(0, -64'sd2147483648, 64'sd2147483647);
		push_load(1, 64'sd2147483647, -64'sd2147483648);
		push_query(-64'sd2147483648);
		push_query(64'sd2147483647);
		push_query(0);
		push_query(-1);
		drain();
		write_reg(CFG_EXTRAP, 1);
		push_query(-64'sd2147483648);
		push_query(64'sd2147483647);
		push_query(12345);
		drain();
		// zero-width first segment, interior walk, extrapolation and saturation
		write_reg(CFG_POINT_COUNT, 3);
		push_load(0, 0, 100 << 16);
		push_load(1, 0, 5);
		push_load(2, 10 << 16, 20 << 16);
		push_query(-5);
		push_query(5 << 16);
		push_query(20 << 16);
		push_load(2, 1, 64'sh7FFF0000);
		push_query(64'sd2147483647);
		push_query(-64'sd2147483648);
		drain();
		write_reg(CFG_POINT_COUNT, 1);
		write_reg(CFG_EXTRAP, 0);
		push_query(777);
		push_query(-64'sd2147483648);
		drain();

		total = 0;
		while (total < 400) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				n = 64;
			else if (r < 14)
				n = 1;
			else if (r < 17)
				n = 0;
			else if (r < 20)
				n = 127;
			else
				n = $urandom_range(2, 12);
			write_reg(CFG_POINT_COUNT, n);
			write_reg(CFG_EXTRAP, $urandom_range(0, 1));
			n = n < 1 ? 1 : (n > 64 ? 64 : n);
			steady = ($urandom_range(0, 3) == 0);
			narrow = $urandom_range(0, 1);
			span = 64'sh1_0000_0000 / n;
			step = $urandom_range(1, 4096);
			base = -(n * step) / 2 + $urandom_range(0, 1000);
			for (int i = 0; i < n; i++) begin
				if (narrow)
					gx[i] = (i > 0 && $urandom_range(0, 9) == 0) ? gx[i-1] : base + i * step;
				else
					gx[i] = -64'sd2147483648 + i * span + $urandom_range(0, span - 1);
				if ($urandom_range(0, 2) == 0)
					push_load(i, gx[i], $signed($urandom));
				else
					push_load(i, gx[i], longint'($urandom_range(0, 1 << 22)) - (1 << 21));
			end
			nq = $urandom_range(20, 40);
			for (int q = 0; q < nq; q++) begin
				r = $urandom_range(0, 99);
				j = $urandom_range(0, n - 1);
				if (r < 8)
					push_load($urandom_range(0, 63), $signed($urandom), $signed($urandom));
				else if (r < 30)
					push_query(gx[j]);
				else if (r < 70)
					push_query(gx[j] + $urandom_range(0, narrow ? step : span - 1));
				else
					push_query($signed($urandom));
			end
			total += n + nq;
			drain();
		end

		$display("Covered %0d loads and %0d queries, %0d results checked, %0d mismatches.",
			loads_sent, queries_sent, results_seen, mismatches);
		if (mismatches == 0 && expected_interps.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/tli_pkg.sv
hdl/tli_if.sv
hdl/tli_ram.sv
hdl/tli_div.sv
hdl/table_linear_interpolator.sv
hdl/tli_checker.sv
verif/table_linear_interpolator_test.sv
